>>> rtl/isp_memory_write_command_sequencer_core_defines.svh
// assertion macros used by the command sequencer core
`ifndef ISP_MEMORY_WRITE_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define ISP_MEMORY_WRITE_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IMWCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imwcs assertion failed");

// next-cycle implication, checked outside reset
`define IMWCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imwcs assertion failed");

`endif

>>> rtl/imwcs_pkg.sv
// types and constants of the isp write command sequencer
`timescale 1ns / 1ps
`default_nettype none
package imwcs_pkg;

  localparam int ADDR_W     = 24;
  localparam int PAGE_W     = 16;
  localparam int DIV_W      = PAGE_W + 1;
  localparam int MOD_STEPS  = 13;
  localparam int DIVIDEND_W = 2 * MOD_STEPS;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    FK_EXT,
    FK_FLOAD,
    FK_FWRITE,
    FK_EBYTE,
    FK_ELOAD,
    FK_EWRITE
  } frame_kind_t;

  typedef enum logic [1:0] {
    WAIT_NONE   = 2'd0,
    WAIT_FLASH  = 2'd1,
    WAIT_EEPROM = 2'd2
  } wait_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEMORY_SELECT,
    CFG_PAGE_SIZE,
    CFG_OP_LOAD_EXTENDED,
    CFG_OP_FLASH_LOAD_LOW,
    CFG_OP_FLASH_WRITE_PAGE,
    CFG_OP_EEPROM_WRITE_BYTE,
    CFG_OP_EEPROM_LOAD_PAGE,
    CFG_OP_EEPROM_WRITE_PAGE
  } cfg_index_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_status_t;

endpackage
`default_nettype wire

>>> rtl/isp_memory_write_command_sequencer_core.sv
// Serial-programming write sequencer: takes one byte with its 24-bit target
// address and block marks and emits one to three four-byte command frames
// (extended-address load, page load or byte write, page write), each tagged
// with its wait code on m_tuser and the final frame of the request flagged by
// m_tlast. Requests are handled one at a time: after acceptance the page-end
// test runs through a remainder unit that consumes two address bits per cycle,
// then the frames leave at one per cycle while m_tready allows. The last frame
// sits in an output register, so the next request is taken while it waits.
// Configuration must be written only while idle; the block itself does not
// enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "isp_memory_write_command_sequencer_core_defines.svh"
module isp_memory_write_command_sequencer_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [imwcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [imwcs_pkg::PAGE_W-1:0]     cfg_data,
  // request side
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [31:0]                      s_tdata,  // target_address, data_byte
  input  wire logic                             s_tuser,  // block_start
  input  wire logic                             s_tlast,  // block_end
  // frame side
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [31:0]                           m_tdata,  // frame_byte0..frame_byte3
  output logic [1:0]                            m_tuser,  // wait_after
  output logic                                  m_tlast   // last_frame
);
  import imwcs_pkg::*;

  // configuration registers
  logic              memory_select;
  logic [PAGE_W-1:0] page_size;
  logic [7:0]        op_load_extended;
  logic [7:0]        op_flash_load_low;
  logic [7:0]        op_flash_write_page;
  logic [7:0]        op_eeprom_write_byte;
  logic [7:0]        op_eeprom_load_page;
  logic [7:0]        op_eeprom_write_page;

  logic [7:0]        held;

  // latched request
  logic [ADDR_W-1:0] addr;
  logic [7:0]        data;
  logic              blk_end;
  logic              need_ext;
  logic              flush;

  state_t            state;
  state_t            state_next;
  frame_kind_t       kind;
  frame_kind_t       kind_next;
  frame_kind_t       first_kind;
  logic              has_next;

  logic              accept;
  logic              emit_fire;
  logic              single_byte;
  logic [7:0]        hi_in;
  logic [7:0]        held_eff;
  logic              ext_in;

  logic [DIVIDEND_W-1:0] dividend;
  logic [DIV_W-1:0]      divisor;
  mod_status_t           mod_status;

  logic [31:0]       frame;
  wait_code_t        frame_wait;

  assign accept      = s_tvalid && s_tready;
  assign single_byte = (page_size[PAGE_W-1:1] == '0);
  assign hi_in       = {1'b0, s_tdata[ADDR_W-1:17]};
  assign held_eff    = s_tuser ? 8'hff : held;
  assign ext_in      = (hi_in != held_eff);

  // address + 1 padded to a whole number of digits; page size 0 means 65536
  assign dividend = DIVIDEND_W'({1'b0, s_tdata[ADDR_W-1:0]} + (ADDR_W + 1)'(1));
  assign divisor  = (page_size == '0) ? {1'b1, {PAGE_W{1'b0}}} : {1'b0, page_size};

  imwcs_page_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (dividend),
    .divisor  (divisor),
    .status   (mod_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_select        <= 1'b0;
      page_size            <= PAGE_W'(128);
      op_load_extended     <= 8'd77;
      op_flash_load_low    <= 8'd64;
      op_flash_write_page  <= 8'd76;
      op_eeprom_write_byte <= 8'd192;
      op_eeprom_load_page  <= 8'd193;
      op_eeprom_write_page <= 8'd194;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEMORY_SELECT:        memory_select        <= cfg_data[0];
        CFG_PAGE_SIZE:            page_size            <= cfg_data;
        CFG_OP_LOAD_EXTENDED:     op_load_extended     <= cfg_data[7:0];
        CFG_OP_FLASH_LOAD_LOW:    op_flash_load_low    <= cfg_data[7:0];
        CFG_OP_FLASH_WRITE_PAGE:  op_flash_write_page  <= cfg_data[7:0];
        CFG_OP_EEPROM_WRITE_BYTE: op_eeprom_write_byte <= cfg_data[7:0];
        CFG_OP_EEPROM_LOAD_PAGE:  op_eeprom_load_page  <= cfg_data[7:0];
        CFG_OP_EEPROM_WRITE_PAGE: op_eeprom_write_page <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // held extended address only moves in flash mode, or on block start
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'hff;
    end else if (accept) begin
      if (!memory_select && ext_in) begin
        held <= hi_in;
      end else begin
        held <= held_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr     <= s_tdata[ADDR_W-1:0];
      data     <= s_tdata[31:24];
      blk_end  <= s_tlast;
      need_ext <= !memory_select && ext_in;
    end
    if (state == ST_DIVIDE && mod_status.done) begin
      flush <= mod_status.zero || blk_end;
    end
  end

  always_comb begin
    if (!memory_select) begin
      first_kind = need_ext ? FK_EXT : FK_FLOAD;
    end else if (single_byte) begin
      first_kind = FK_EBYTE;
    end else begin
      first_kind = FK_ELOAD;
    end
  end

  // frame order within one request
  always_comb begin
    has_next  = 1'b0;
    kind_next = kind;
    unique case (kind)
      FK_EXT: begin
        has_next  = 1'b1;
        kind_next = FK_FLOAD;
      end
      FK_FLOAD: begin
        has_next  = flush;
        kind_next = FK_FWRITE;
      end
      FK_ELOAD: begin
        has_next  = flush;
        kind_next = FK_EWRITE;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_DIVIDE;
      ST_DIVIDE: if (mod_status.done) state_next = ST_EMIT;
      ST_EMIT:   if (emit_fire && !has_next) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    emit_fire = (state == ST_EMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && mod_status.done) begin
      kind <= first_kind;
    end else if (emit_fire && has_next) begin
      kind <= kind_next;
    end
  end

  always_comb begin
    frame      = '0;
    frame_wait = WAIT_NONE;
    case (kind)
      FK_EXT:    frame = {8'h00, {1'b0, addr[ADDR_W-1:17]}, 8'h00, op_load_extended};
      FK_FLOAD:  frame = {data, addr[8:1], addr[16:9],
                          op_flash_load_low | {4'b0000, addr[0], 3'b000}};
      FK_FWRITE: begin
        frame      = {8'h00, addr[8:1], addr[16:9], op_flash_write_page};
        frame_wait = WAIT_FLASH;
      end
      FK_EBYTE: begin
        frame      = {data, addr[7:0], addr[15:8], op_eeprom_write_byte};
        frame_wait = WAIT_EEPROM;
      end
      FK_ELOAD:  frame = {data, addr[7:0], addr[15:8], op_eeprom_load_page};
      FK_EWRITE: begin
        frame      = {8'h00, addr[7:0] & 8'hfc, addr[15:8], op_eeprom_write_page};
        frame_wait = WAIT_EEPROM;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= frame;
      m_tuser <= frame_wait;
      m_tlast <= !has_next;
    end
  end

  `IMWCS_ASSERT_NEXT(a_accept_starts_divide, clk, rst, accept, state == ST_DIVIDE)
  `IMWCS_ASSERT_NOW(a_done_only_in_divide, clk, rst, mod_status.done, state == ST_DIVIDE)
  `IMWCS_ASSERT_NEXT(a_last_frame_to_idle, clk, rst, (emit_fire && !has_next),
                     (state == ST_IDLE && m_tvalid && m_tlast))
  `IMWCS_ASSERT_NEXT(a_ext_updates_held, clk, rst, (accept && !memory_select && ext_in),
                     (held == {1'b0, addr[ADDR_W-1:17]}))

endmodule
`default_nettype wire

>>> rtl/imwcs_page_mod.sv
// radix-4 serial remainder unit: is (address + 1) a multiple of the page size
`timescale 1ns / 1ps
`default_nettype none
module imwcs_page_mod (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [imwcs_pkg::DIVIDEND_W-1:0]  dividend,
  input  wire logic [imwcs_pkg::DIV_W-1:0]       divisor,
  output imwcs_pkg::mod_status_t                 status
);
  import imwcs_pkg::*;

  localparam int CNT_W = $clog2(MOD_STEPS + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      count;
  logic [DIVIDEND_W-1:0] sh;
  logic [DIV_W-1:0]      dv;
  logic [DIV_W-1:0]      rem;
  logic [DIV_W-1:0]      rem_next;
  logic [DIV_W:0]        r1;
  logic [DIV_W:0]        s1;
  logic [DIV_W:0]        r2;
  logic [DIV_W:0]        s2;

  // two restoring steps per cycle, msb first
  always_comb begin
    r1 = {rem, sh[DIVIDEND_W-1]};
    s1 = (r1 >= {1'b0, dv}) ? r1 - {1'b0, dv} : r1;
    r2 = {s1[DIV_W-1:0], sh[DIVIDEND_W-2]};
    s2 = (r2 >= {1'b0, dv}) ? r2 - {1'b0, dv} : r2;
    rem_next = s2[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(MOD_STEPS);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      dv  <= divisor;
      rem <= '0;
    end else if (busy) begin
      sh  <= {sh[DIVIDEND_W-3:0], 2'b00};
      rem <= rem_next;
    end
  end

  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule
`default_nettype wire

>>> bench/testbench.sv
// testbench for the isp write command sequencer: directed and random requests against a predictor
`timescale 1ns / 1ps
module testbench;
  import imwcs_pkg::*;

  typedef struct packed {
    logic [23:0] addr;
    logic [7:0]  data;
    logic        blk_start;
    logic        blk_end;
  } prog_req_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    wait_code_t wt;
    logic       last;
  } isp_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PAGE_W-1:0]    cfg_data = '0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // target_address, data_byte
  logic        s_tuser = 1'b0; // block_start
  logic        s_tlast = 1'b0; // block_end

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // frame_byte0..frame_byte3
  logic [1:0]  m_tuser;        // wait_after
  logic        m_tlast;        // last_frame

  isp_memory_write_command_sequencer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // shadow of the configuration and the held extended address
  logic        sel_eeprom = 1'b0;
  logic [15:0] page_len = 16'd128;
  logic [7:0]  op_ext = 8'd77;
  logic [7:0]  op_fload = 8'd64;
  logic [7:0]  op_fwrite = 8'd76;
  logic [7:0]  op_ebyte = 8'd192;
  logic [7:0]  op_eload = 8'd193;
  logic [7:0]  op_ewrite = 8'd194;
  logic [7:0]  ext_held = 8'hff;

  prog_req_t  pending[$];
  isp_frame_t frames_due[$];

  prog_req_t cur_req;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  burst = 1'b0;
  int  errors = 0;
  int  reqs_taken = 0;
  int  frames_seen = 0;
  int  settings_run = 1;
  int  rand_queued = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic isp_frame_t make_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                            logic [7:0] b3, wait_code_t wt);
    isp_frame_t f;
    f.b0 = b0;
    f.b1 = b1;
    f.b2 = b2;
    f.b3 = b3;
    f.wt = wt;
    f.last = 1'b0;
    return f;
  endfunction

  // frames that one programming request turns into
  function automatic void expand_request(prog_req_t r);
    isp_frame_t  fr[3];
    int          n;
    int unsigned nxt;
    int unsigned plen;
    logic [7:0]  hi;
    n = 0;
    nxt = int'(r.addr) + 1;
    hi = {1'b0, r.addr[23:17]};
    if (r.blk_start)
      ext_held = 8'hff;
    if (!sel_eeprom) begin
      plen = (page_len == 16'd0) ? 65536 : int'(page_len);
      if (hi != ext_held) begin
        ext_held = hi;
        fr[n] = make_frame(op_ext, 8'h00, hi, 8'h00, WAIT_NONE);
        n++;
      end
      fr[n] = make_frame(op_fload | {4'b0, r.addr[0], 3'b0}, r.addr[16:9], r.addr[8:1],
                         r.data, WAIT_NONE);
      n++;
      if ((nxt % plen) == 0 || r.blk_end) begin
        fr[n] = make_frame(op_fwrite, r.addr[16:9], r.addr[8:1], 8'h00, WAIT_FLASH);
        n++;
      end
    end else if (page_len <= 16'd1) begin
      fr[n] = make_frame(op_ebyte, r.addr[15:8], r.addr[7:0], r.data, WAIT_EEPROM);
      n++;
    end else begin
      fr[n] = make_frame(op_eload, r.addr[15:8], r.addr[7:0], r.data, WAIT_NONE);
      n++;
      if ((nxt % int'(page_len)) == 0 || r.blk_end) begin
        fr[n] = make_frame(op_ewrite, r.addr[15:8], {r.addr[7:2], 2'b00}, 8'h00, WAIT_EEPROM);
        n++;
      end
    end
    fr[n-1].last = 1'b1;
    for (int i = 0; i < n; i++)
      frames_due.push_back(fr[i]);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expand_request(cur_req);
        reqs_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_req = pending.pop_front();
          s_tdata <= {cur_req.data, cur_req.addr};
          s_tuser <= cur_req.blk_start;
          s_tlast <= cur_req.blk_end;
          s_tvalid <= 1'b1;
          gap_left <= burst ? 0 : $urandom_range(0, 7);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // frame monitor and checker
  always @(posedge clk) begin
    isp_frame_t got;
    isp_frame_t exp;
    int         stall;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      got = make_frame(m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
                       wait_code_t'(m_tuser));
      got.last = m_tlast;
      frames_seen++;
      if (frames_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected frame %02h %02h %02h %02h wait %0d last %0b", $realtime,
                   got.b0, got.b1, got.b2, got.b3, got.wt, got.last);
      end else begin
        exp = frames_due.pop_front();
        if (got.b0 !== exp.b0 || got.b1 !== exp.b1 || got.b2 !== exp.b2 ||
            got.b3 !== exp.b3 || got.wt !== exp.wt || got.last !== exp.last) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: frame mismatch: expected %02h %02h %02h %02h wait %0d last %0b,",
                      " got %02h %02h %02h %02h wait %0d last %0b"},
                     $realtime, exp.b0, exp.b1, exp.b2, exp.b3, exp.wt, exp.last,
                     got.b0, got.b1, got.b2, got.b3, got.wt, got.last);
        end
      end
      stall = burst ? 0 : $urandom_range(0, 7);
      stall_left <= stall;
      m_tready <= (stall == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= (stall_left == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MEMORY_SELECT:        sel_eeprom = val[0];
      CFG_PAGE_SIZE:            page_len = val;
      CFG_OP_LOAD_EXTENDED:     op_ext = val[7:0];
      CFG_OP_FLASH_LOAD_LOW:    op_fload = val[7:0];
      CFG_OP_FLASH_WRITE_PAGE:  op_fwrite = val[7:0];
      CFG_OP_EEPROM_WRITE_BYTE: op_ebyte = val[7:0];
      CFG_OP_EEPROM_LOAD_PAGE:  op_eload = val[7:0];
      CFG_OP_EEPROM_WRITE_PAGE: op_ewrite = val[7:0];
      default: ;
    endcase
  endtask

  task automatic queue_req(input logic [23:0] addr, input logic [7:0] data,
                           input logic blk_start, input logic blk_end);
    prog_req_t r;
    r.addr = addr;
    r.data = data;
    r.blk_start = blk_start;
    r.blk_end = blk_end;
    pending.push_back(r);
  endtask

  // wait until every request is taken and every frame is back
  task automatic settle();
    @(negedge clk);
    while (pending.size() != 0 || s_tvalid || frames_due.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  initial begin
    logic [23:0] base;
    int          len;
    logic [15:0] psz;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: flash, 128-byte pages
    queue_req(24'h000000, 8'h00, 1'b1, 1'b0);
    queue_req(24'h000001, 8'hff, 1'b0, 1'b0);
    queue_req(24'h00007f, 8'ha5, 1'b0, 1'b0);
    queue_req(24'h020000, 8'h5a, 1'b0, 1'b0);
    queue_req(24'hffffff, 8'hff, 1'b1, 1'b1);
    queue_req(24'h123456, 8'h3c, 1'b0, 1'b1);
    settle();

    // flash with zero page size meaning 64k pages, extreme command codes
    write_reg(CFG_MEMORY_SELECT, 16'd0);
    write_reg(CFG_PAGE_SIZE, 16'd0);
    write_reg(CFG_OP_LOAD_EXTENDED, 16'h00);
    write_reg(CFG_OP_FLASH_LOAD_LOW, 16'hff);
    write_reg(CFG_OP_FLASH_WRITE_PAGE, 16'hff);
    settings_run++;
    @(negedge clk);
    queue_req(24'h00ffff, 8'h01, 1'b1, 1'b0);
    queue_req(24'h010000, 8'h80, 1'b0, 1'b0);
    queue_req(24'h00fffe, 8'h7f, 1'b0, 1'b0);
    settle();

    // eeprom with zero page size: single byte writes, held address kept
    write_reg(CFG_MEMORY_SELECT, 16'd1);
    write_reg(CFG_OP_EEPROM_WRITE_BYTE, 16'hff);
    settings_run++;
    @(negedge clk);
    queue_req(24'habcdef, 8'h11, 1'b0, 1'b1);
    queue_req(24'h000000, 8'hff, 1'b0, 1'b0);
    settle();

    // back to flash, one-byte pages: no extended load expected
    write_reg(CFG_MEMORY_SELECT, 16'd0);
    write_reg(CFG_PAGE_SIZE, 16'd1);
    settings_run++;
    @(negedge clk);
    queue_req(24'h000055, 8'h66, 1'b0, 1'b0);
    settle();

    write_reg(CFG_MEMORY_SELECT, 16'd1);
    write_reg(CFG_OP_EEPROM_WRITE_BYTE, 16'h00);
    settings_run++;
    @(negedge clk);
    queue_req(24'hffffff, 8'h80, 1'b1, 1'b1);
    settle();

    // eeprom with the largest page
    write_reg(CFG_PAGE_SIZE, 16'hffff);
    write_reg(CFG_OP_EEPROM_LOAD_PAGE, 16'h00);
    write_reg(CFG_OP_EEPROM_WRITE_PAGE, 16'hff);
    settings_run++;
    @(negedge clk);
    queue_req(24'h00fffe, 8'hc3, 1'b0, 1'b0);
    queue_req(24'h000103, 8'h3c, 1'b0, 1'b1);
    queue_req(24'h000010, 8'h99, 1'b0, 1'b0);
    settle();

    // random settings, each followed by a few blocks of consecutive bytes or stray bytes
    while (rand_queued < 150) begin
      case ($urandom_range(0, 9))
        0: psz = 16'd0;
        1: psz = 16'd1;
        2: psz = 16'd2;
        3: psz = 16'd3;
        4: psz = 16'd4;
        5: psz = 16'd8;
        6: psz = 16'd16;
        7: psz = 16'($urandom_range(2, 64));
        8: psz = 16'hffff;
        default: psz = 16'd128;
      endcase
      write_reg(CFG_MEMORY_SELECT, 16'($urandom_range(0, 1)));
      write_reg(CFG_PAGE_SIZE, psz);
      write_reg(CFG_OP_LOAD_EXTENDED, 16'($urandom_range(0, 255)));
      write_reg(CFG_OP_FLASH_LOAD_LOW, 16'($urandom_range(0, 255)));
      write_reg(CFG_OP_FLASH_WRITE_PAGE, 16'($urandom_range(0, 255)));
      write_reg(CFG_OP_EEPROM_WRITE_BYTE, 16'($urandom_range(0, 255)));
      write_reg(CFG_OP_EEPROM_LOAD_PAGE, 16'($urandom_range(0, 255)));
      write_reg(CFG_OP_EEPROM_WRITE_PAGE, 16'($urandom_range(0, 255)));
      settings_run++;
      @(negedge clk);
      burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 4) == 0) begin
          // stray byte with arbitrary marks
          queue_req(24'($urandom), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          rand_queued++;
        end else begin
          base = 24'($urandom);
          // start just below a 128k boundary so the extended address moves mid-block
          if ($urandom_range(0, 1) == 1)
            base = (base | 24'h01ffff) - 24'($urandom_range(0, 5));
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++)
            queue_req(base + 24'(i), 8'($urandom_range(0, 255)), i == 0, i == len - 1);
          rand_queued += len;
        end
      end
      settle();
      burst = 1'b0;
    end

    repeat (20) @(negedge clk);
    if (frames_due.size() != 0)
      errors++;
    $display("requests taken: %0d, command frames checked: %0d", reqs_taken, frames_seen);
    $display("register settings exercised: %0d, mismatches: %0d", settings_run, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d frames outstanding", frames_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
